### design/mse_pkg.sv
// Shared types, constants and the register preset table for the MIPS subset executor.
`default_nettype none
package mse_pkg;

  // Data memory geometry: four byte banks, one per byte lane
  localparam int MEM_ADDR_BITS = 16;
  localparam int BANK_ROW_BITS = MEM_ADDR_BITS - 2;
  localparam int BANK_DEPTH    = 1 << BANK_ROW_BITS;
  localparam int NUM_REGS      = 32;

  localparam logic [31:0] START_PC  = 32'h0000_1000;
  localparam logic [31:0] HALT_WORD = 32'hffff_ffff;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes under the special opcode
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR  = 6'h08;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a;

  localparam logic [4:0] LINK_REG = 5'd31;

  // Register file write
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  // One result item
  typedef struct packed {
    logic        status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        mem_written;
    logic [15:0] store_address;
    logic [31:0] store_value;
  } result_t;

  // Execute stage outcome
  typedef struct packed {
    result_t                  res;
    logic                     is_load;
    logic [MEM_ADDR_BITS-1:0] ea;
  } exec_t;

  // Register contents after reset
  function automatic logic [31:0] reg_preset(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd16:   v = 32'h0000_0010;
      5'd17:   v = START_PC;
      5'd18:   v = 32'h0000_0020;
      5'd19:   v = 32'h0000_0003;
      5'd20:   v = 32'hbada_cafe;
      5'd21:   v = 32'hcdcd_cdcd;
      5'd22:   v = 32'hffff_ffff;
      5'd23:   v = 32'h0000_0007;
      5'd29:   v = 32'h0000_8000;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/mse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### design/mse_regfile.sv
// Register file: two RAM copies for two read ports, preset via valid bits, write forwarding.
`default_nettype none
module mse_regfile (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [4:0]      ra_idx,
  input  wire logic [4:0]      rb_idx,
  input  wire mse_pkg::rf_wr_t wr,
  output logic      [31:0]     ra_data,
  output logic      [31:0]     rb_data
);

  logic [31:0]      ram_a;
  logic [31:0]      ram_b;
  logic [mse_pkg::NUM_REGS-1:0] valid_r;
  mse_pkg::rf_wr_t  fwd_r;
  logic [4:0]       ra_idx_r;
  logic [4:0]       rb_idx_r;
  logic             ra_vld_r;
  logic             rb_vld_r;

  mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_ram_a (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.data),
    .raddr (ra_idx),
    .rdata (ram_a)
  );

  mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_ram_b (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.data),
    .raddr (rb_idx),
    .rdata (ram_b)
  );

  // Valid bits and the write made at the read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fwd_r   <= '0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      fwd_r <= wr;
    end
  end

  // Read-side bookkeeping, captured with the RAM read
  always_ff @(posedge clk) begin
    ra_idx_r   <= ra_idx;
    rb_idx_r   <= rb_idx;
    ra_vld_r   <= valid_r[ra_idx];
    rb_vld_r   <= valid_r[rb_idx];
  end

  // r0 reads zero; a fresh write wins; an unwritten entry reads its preset
  always_comb begin
    if (ra_idx_r == 5'd0) begin
      ra_data = 32'd0;
    end else if (fwd_r.en && fwd_r.idx == ra_idx_r) begin
      ra_data = fwd_r.data;
    end else if (ra_vld_r) begin
      ra_data = ram_a;
    end else begin
      ra_data = mse_pkg::reg_preset(ra_idx_r);
    end

    if (rb_idx_r == 5'd0) begin
      rb_data = 32'd0;
    end else if (fwd_r.en && fwd_r.idx == rb_idx_r) begin
      rb_data = fwd_r.data;
    end else if (rb_vld_r) begin
      rb_data = ram_b;
    end else begin
      rb_data = mse_pkg::reg_preset(rb_idx_r);
    end
  end

endmodule
`default_nettype wire

### design/mse_datamem.sv
// Byte-addressed big-endian data memory built from four byte-lane banks.
`default_nettype none
module mse_datamem (
  input  wire logic                              clk,
  input  wire logic [mse_pkg::MEM_ADDR_BITS-1:0] ea,
  input  wire logic                              store_en,
  input  wire logic [31:0]                       store_word,
  output logic      [31:0]                       load_word
);

  logic [7:0] bank_q [4];

  // Byte i of the word lies at ea+i, in bank (ea+i) mod 4
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]                      off;
    logic [mse_pkg::MEM_ADDR_BITS-1:0] addr;
    logic [7:0]                      wbyte;

    assign off  = 2'(k) - ea[1:0];
    assign addr = ea + mse_pkg::MEM_ADDR_BITS'(off);

    always_comb begin
      unique case (off)
        2'd0:    wbyte = store_word[31:24];
        2'd1:    wbyte = store_word[23:16];
        2'd2:    wbyte = store_word[15:8];
        default: wbyte = store_word[7:0];
      endcase
    end

    mse_ram #(.WIDTH(8), .DEPTH(mse_pkg::BANK_DEPTH)) u_bank (
      .clk   (clk),
      .we    (store_en),
      .waddr (addr[mse_pkg::MEM_ADDR_BITS-1:2]),
      .wdata (wbyte),
      .raddr (addr[mse_pkg::MEM_ADDR_BITS-1:2]),
      .rdata (bank_q[k])
    );
  end

  // Reassemble, first byte most significant
  assign load_word = {bank_q[ea[1:0]],
                      bank_q[2'(ea[1:0] + 2'd1)],
                      bank_q[2'(ea[1:0] + 2'd2)],
                      bank_q[2'(ea[1:0] + 2'd3)]};

endmodule
`default_nettype wire

### design/mse_alu.sv
// Execute logic: decode, ALU, branch and jump targets, result item assembly.
`default_nettype none
module mse_alu (
  input  wire logic [31:0]    instr,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  input  wire logic [31:0]    pc,
  input  wire logic [31:0]    load_word,
  output mse_pkg::exec_t      ex
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm_s;
  logic [31:0] imm_z;
  logic [31:0] ea_full;
  logic [31:0] pc4;
  logic [31:0] br_target;
  logic [31:0] j_target;
  logic        wr;
  logic [4:0]  dst;
  logic [31:0] val;
  logic [31:0] npc;
  logic        halt;
  logic        st;
  logic        ld;
  logic        wr_ok;

  assign op        = instr[31:26];
  assign rt        = instr[20:16];
  assign rd        = instr[15:11];
  assign sh        = instr[10:6];
  assign fn        = instr[5:0];
  assign imm_s     = {{16{instr[15]}}, instr[15:0]};
  assign imm_z     = {16'd0, instr[15:0]};
  assign ea_full   = a + imm_s;
  assign pc4       = pc + 32'd4;
  assign br_target = pc4 + {imm_s[29:0], 2'b00};
  assign j_target  = {pc4[31:28], instr[25:0], 2'b00};

  // Decode and execute
  always_comb begin
    wr   = 1'b0;
    dst  = 5'd0;
    val  = 32'd0;
    npc  = pc4;
    halt = 1'b0;
    st   = 1'b0;
    ld   = 1'b0;
    if (instr == mse_pkg::HALT_WORD) begin
      halt = 1'b1;
    end else if (op == mse_pkg::OP_SPECIAL) begin
      wr  = 1'b1;
      dst = rd;
      unique case (fn)
        mse_pkg::FN_ADD: val = a + b;
        mse_pkg::FN_SUB: val = a - b;
        mse_pkg::FN_AND: val = a & b;
        mse_pkg::FN_OR:  val = a | b;
        mse_pkg::FN_NOR: val = ~(a | b);
        mse_pkg::FN_SLL: val = b << sh;
        mse_pkg::FN_SRL: val = b >> sh;
        mse_pkg::FN_SRA: val = 32'($signed(b) >>> sh);
        mse_pkg::FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
        mse_pkg::FN_JR: begin
          wr  = 1'b0;
          npc = a;
        end
        default: wr = 1'b0;
      endcase
    end else begin
      unique case (op)
        mse_pkg::OP_ADDI: begin
          wr = 1'b1; dst = rt; val = ea_full;
        end
        mse_pkg::OP_ANDI: begin
          wr = 1'b1; dst = rt; val = a & imm_z;
        end
        mse_pkg::OP_ORI: begin
          wr = 1'b1; dst = rt; val = a | imm_z;
        end
        mse_pkg::OP_SLTI: begin
          wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(imm_s)};
        end
        mse_pkg::OP_LW: begin
          wr = 1'b1; dst = rt; val = load_word; ld = 1'b1;
        end
        mse_pkg::OP_SW: st = 1'b1;
        mse_pkg::OP_BEQ: begin
          if (a == b) npc = br_target;
        end
        mse_pkg::OP_BNE: begin
          if (a != b) npc = br_target;
        end
        mse_pkg::OP_JAL: begin
          wr = 1'b1; dst = mse_pkg::LINK_REG; val = pc4; npc = j_target;
        end
        mse_pkg::OP_J: npc = j_target;
        default: ;
      endcase
    end
  end

  // Writes to r0 are dropped; unused fields read zero
  assign wr_ok = wr && (dst != 5'd0);

  always_comb begin
    ex.res.status        = halt;
    ex.res.next_pc       = npc;
    ex.res.reg_written   = wr_ok;
    ex.res.dest_index    = wr_ok ? dst : 5'd0;
    ex.res.dest_value    = wr_ok ? val : 32'd0;
    ex.res.mem_written   = st;
    ex.res.store_address = st ? 16'(ea_full[mse_pkg::MEM_ADDR_BITS-1:0]) : 16'd0;
    ex.res.store_value   = st ? b : 32'd0;
    ex.is_load           = ld;
    ex.ea                = ea_full[mse_pkg::MEM_ADDR_BITS-1:0];
  end

endmodule
`default_nettype wire

### design/mips_subset_instruction_executor.sv
// Top level: execute stage, program counter and output register of the MIPS subset executor.
//
//  channel | ports                         | direction | carries
//  --------+-------------------------------+-----------+--------------------------------
//  in      | in_valid/in_ready/in_instr_word | in      | one instruction word per item
//  out     | out_valid/out_ready/out_*     | out       | status, PC, reg and store report
//
// One item per cycle while the output is not stalled; lw holds the execute stage
// for its load phase, as the data banks return registered read data.
// A result is presented the cycle after the item leaves execute.
// Reset (rst_n low, synchronous): PC to 0x1000, register file to its preset,
// pipeline empty. Data memory is not cleared.
// A stalled output register holds the execute stage, and that holds the input.
`default_nettype none
module mips_subset_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_instr_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic      [31:0] out_next_pc,
  output logic             out_reg_written,
  output logic      [4:0]  out_dest_index,
  output logic      [31:0] out_dest_value,
  output logic             out_mem_written,
  output logic      [15:0] out_store_address,
  output logic      [31:0] out_store_value
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             s1_phase_r;
  logic             s1_phase_nxt;
  logic [31:0]      s1_instr_r;
  logic [31:0]      pc_r;
  logic             out_valid_r;
  mse_pkg::result_t out_res_r;
  logic             in_fire;
  logic             s1_done;
  logic [4:0]       ra_idx;
  logic [4:0]       rb_idx;
  logic [31:0]      a;
  logic [31:0]      b;
  logic [31:0]      load_word;
  mse_pkg::rf_wr_t  rf_wr;
  mse_pkg::exec_t   ex;

  // Execute stage finishes once a load has its data and the output slot frees
  assign s1_done  = s1_valid_r && (!ex.is_load || s1_phase_r) && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_done;
  assign in_fire  = in_valid && in_ready;

  // Operands read for whichever item occupies execute next cycle
  assign ra_idx = in_fire ? in_instr_word[25:21] : s1_instr_r[25:21];
  assign rb_idx = in_fire ? in_instr_word[20:16] : s1_instr_r[20:16];

  assign rf_wr.en   = s1_done && ex.res.reg_written;
  assign rf_wr.idx  = ex.res.dest_index;
  assign rf_wr.data = ex.res.dest_value;

  mse_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_idx  (ra_idx),
    .rb_idx  (rb_idx),
    .wr      (rf_wr),
    .ra_data (a),
    .rb_data (b)
  );

  mse_alu u_alu (
    .instr     (s1_instr_r),
    .a         (a),
    .b         (b),
    .pc        (pc_r),
    .load_word (load_word),
    .ex        (ex)
  );

  mse_datamem u_datamem (
    .clk        (clk),
    .ea         (ex.ea),
    .store_en   (s1_done && ex.res.mem_written),
    .store_word (b),
    .load_word  (load_word)
  );

  // Stage occupancy and load phase
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_phase_nxt = s1_phase_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_phase_nxt = 1'b0;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
      s1_phase_nxt = 1'b0;
    end else if (s1_valid_r && ex.is_load) begin
      s1_phase_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_phase_r  <= 1'b0;
      pc_r        <= mse_pkg::START_PC;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_phase_r <= s1_phase_nxt;
      if (s1_done) begin
        pc_r        <= ex.res.next_pc;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr_word;
    end
    if (s1_done) begin
      out_res_r <= ex.res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_next_pc       = out_res_r.next_pc;
  assign out_reg_written   = out_res_r.reg_written;
  assign out_dest_index    = out_res_r.dest_index;
  assign out_dest_value    = out_res_r.dest_value;
  assign out_mem_written   = out_res_r.mem_written;
  assign out_store_address = out_res_r.store_address;
  assign out_store_value   = out_res_r.store_value;

endmodule
`default_nettype wire
